// ===== rtl/core/psv_pkg.sv =====
package psv_pkg;

   localparam int CoordWidth = 32;
   localparam int FracBits   = 16;

   localparam logic CsrPredictTimeLimit = 1'b0;
   localparam logic CsrAccelLimit       = 1'b1;

   localparam logic [CoordWidth-1:0] CfgResetValue = 32'h0001_0000;
   localparam logic [CoordWidth-1:0] PosMax        = 32'h7fff_ffff;
   localparam logic [CoordWidth-1:0] NegMaxMag     = 32'h8000_0000;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      logic [2:0][31:0] tv;
      logic [2:0][32:0] d;
   } kin_type;

   typedef struct packed {
      logic    tsat;
      kin_type kin;
   } tside_type;

   typedef struct packed {
      logic [2:0]       neg;
      logic [2:0][30:0] q;
   } nrm_type;

   typedef struct packed {
      logic zero;
      logic neg;
   } lane_type;

endpackage

// ===== rtl/core/psv_isqrt.sv =====
module psv_isqrt #(
   parameter int IN_WIDTH   = 66,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    valid_in,
   input  logic [IN_WIDTH-1:0]     radicand,
   input  logic [SIDE_WIDTH-1:0]   side_in,
   output logic                    valid_out,
   output logic [IN_WIDTH/2-1:0]   root,
   output logic [SIDE_WIDTH-1:0]   side_out
);

   localparam int Steps    = IN_WIDTH / 2;
   localparam int RemWidth = Steps + 2;

   logic [RemWidth-1:0]   rem_ff  [Steps];
   logic [Steps-1:0]      root_ff [Steps];
   logic [IN_WIDTH-1:0]   rad_ff  [Steps];
   logic [SIDE_WIDTH-1:0] side_ff [Steps];
   logic [Steps-1:0]      valid_ff;

   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic [RemWidth-1:0]   rem_prev;
      logic [Steps-1:0]      root_prev;
      logic [IN_WIDTH-1:0]   rad_prev;
      logic [SIDE_WIDTH-1:0] side_prev;
      logic                  valid_prev;
      logic [RemWidth-1:0]   trial;
      logic [RemWidth-1:0]   test;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = radicand;
         assign side_prev  = side_in;
         assign valid_prev = valid_in;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign trial = {rem_prev[RemWidth-3:0], rad_prev[IN_WIDTH-1 -: 2]};
      assign test  = {root_prev, 2'b01};

      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= test) begin
               rem_ff[k]  <= trial - test;
               root_ff[k] <= {root_prev[Steps-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= trial;
               root_ff[k] <= {root_prev[Steps-2:0], 1'b0};
            end
            rad_ff[k]  <= rad_prev << 2;
            side_ff[k] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end
   end

   assign valid_out = valid_ff[Steps-1];
   assign root      = root_ff[Steps-1];
   assign side_out  = side_ff[Steps-1];

endmodule

// ===== rtl/core/psv_div.sv =====
module psv_div #(
   parameter int QUO_WIDTH  = 32,
   parameter int DEN_WIDTH  = 33,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  valid_in,
   input  logic [DEN_WIDTH-1:0]  rem_in,
   input  logic [QUO_WIDTH-1:0]  low_in,
   input  logic [DEN_WIDTH-1:0]  den_in,
   input  logic [SIDE_WIDTH-1:0] side_in,
   output logic                  valid_out,
   output logic [QUO_WIDTH-1:0]  quotient,
   output logic [SIDE_WIDTH-1:0] side_out
);

   // remainder must start below the divisor, so the quotient fits
   logic [DEN_WIDTH-1:0]  rem_ff  [QUO_WIDTH];
   logic [QUO_WIDTH-1:0]  quo_ff  [QUO_WIDTH];
   logic [QUO_WIDTH-1:0]  low_ff  [QUO_WIDTH];
   logic [DEN_WIDTH-1:0]  den_ff  [QUO_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff [QUO_WIDTH];
   logic [QUO_WIDTH-1:0]  valid_ff;

   for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_step
      logic [DEN_WIDTH-1:0]  rem_prev;
      logic [QUO_WIDTH-1:0]  quo_prev;
      logic [QUO_WIDTH-1:0]  low_prev;
      logic [DEN_WIDTH-1:0]  den_prev;
      logic [SIDE_WIDTH-1:0] side_prev;
      logic                  valid_prev;
      logic [DEN_WIDTH:0]    trial;
      logic [DEN_WIDTH:0]    diff;

      if (k == 0) begin : g_first
         assign rem_prev   = rem_in;
         assign quo_prev   = '0;
         assign low_prev   = low_in;
         assign den_prev   = den_in;
         assign side_prev  = side_in;
         assign valid_prev = valid_in;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign low_prev   = low_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign trial = {rem_prev, low_prev[QUO_WIDTH-1]};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= {1'b0, den_prev}) begin
               rem_ff[k] <= diff[DEN_WIDTH-1:0];
               quo_ff[k] <= {quo_prev[QUO_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff[k] <= trial[DEN_WIDTH-1:0];
               quo_ff[k] <= {quo_prev[QUO_WIDTH-2:0], 1'b0};
            end
            low_ff[k]  <= low_prev << 1;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end
   end

   assign valid_out = valid_ff[QUO_WIDTH-1];
   assign quotient  = quo_ff[QUO_WIDTH-1];
   assign side_out  = side_ff[QUO_WIDTH-1];

endmodule

// ===== rtl/core/pursue_steering_vector_core.sv =====
// Pursue steering: per beat, target and agent position and velocity in
// signed Q16.16 go in on the req_ channel; one steering vector (steer_x/y/z,
// signed Q16.16, saturated) comes out on the rsp_ channel.
// csr_ port: index 0 is the maximum prediction time, index 1 the output
// magnitude (both unsigned Q16.16). Write them only while the block is idle.
// Throughput: one beat per cycle while rsp_ready does not stall the output.
// The pipeline is a chain of one-bit-per-stage units: distance/speed
// root (33), time divide (32), offset root (32) and output divide (32),
// plus the multiply and normalizing stages around them.
// The whole pipeline moves with one enable: when rsp_valid is high and
// rsp_ready low, every stage holds and req_ready is low, so nothing is
// lost or repeated; it resumes in the cycle rsp_ready returns.
// Synchronous reset empties the pipeline (all valid bits cleared) and sets
// both limits to 1.0.
module pursue_steering_vector_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  psv_pkg::coord_type        req_tgt_pos_x,
   input  psv_pkg::coord_type        req_tgt_pos_y,
   input  psv_pkg::coord_type        req_tgt_pos_z,
   input  psv_pkg::coord_type        req_tgt_vel_x,
   input  psv_pkg::coord_type        req_tgt_vel_y,
   input  psv_pkg::coord_type        req_tgt_vel_z,
   input  psv_pkg::coord_type        req_own_pos_x,
   input  psv_pkg::coord_type        req_own_pos_y,
   input  psv_pkg::coord_type        req_own_pos_z,
   input  psv_pkg::coord_type        req_own_vel_x,
   input  psv_pkg::coord_type        req_own_vel_y,
   input  psv_pkg::coord_type        req_own_vel_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output psv_pkg::coord_type        rsp_steer_x,
   output psv_pkg::coord_type        rsp_steer_y,
   output psv_pkg::coord_type        rsp_steer_z,
   input  logic                      csr_write_en,
   input  logic                      csr_index,
   input  logic [31:0]               csr_write_data
);

   import psv_pkg::*;

   logic en;

   logic [31:0] time_limit_ff;
   logic [31:0] accel_limit_ff;

   coord_type tp [3];
   coord_type tvi [3];
   coord_type op [3];
   coord_type ov [3];

   // front end
   logic               v1_ff, v2_ff, v3_ff;
   logic signed [32:0] d_in [3];
   logic signed [32:0] d1_ff [3];
   logic [32:0]        dm_in [3];
   logic [32:0]        dm1_ff [3];
   logic [31:0]        vm_in [3];
   logic [31:0]        vm1_ff [3];
   coord_type          tv1_ff [3];
   logic [65:0]        dsq2_ff [3];
   logic [63:0]        vsq2_ff [3];
   logic signed [32:0] d2_ff [3];
   coord_type          tv2_ff [3];
   logic [65:0]        dsum3_ff;
   logic [63:0]        vsum3_ff;
   kin_type            kin3;

   // roots and time
   logic        v4;
   logic [32:0] dist4;
   logic [32:0] spd4;
   kin_type     kin4;
   logic        spd_zero4;
   tside_type   tside_in;
   logic        v5;
   logic [31:0] tq5;
   tside_type   tside5;

   // prediction and normalizing
   logic               v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff;
   logic [31:0]        t6_ff;
   kin_type            kin6_ff;
   logic [31:0]        tvm_in [3];
   logic [62:0]        prod7_ff [3];
   logic [2:0]         tvneg7_ff;
   logic signed [32:0] d7_ff [3];
   logic [48:0]        term_in [3];
   logic [48:0]        pd_in [3];
   logic [48:0]        p8_ff [3];
   logic [48:0]        pneg_in [3];
   logic [47:0]        pm9_ff [3];
   logic [2:0]         neg9_ff;
   logic [47:0]        pm_or;
   logic [4:0]         sh_in;
   logic [4:0]         sh10_ff;
   logic [47:0]        pm10_ff [3];
   logic [2:0]         neg10_ff;
   logic [47:0]        shifted_in [3];
   logic [30:0]        q11_ff [3];
   logic [2:0]         neg11_ff;
   logic [61:0]        qsq12_ff [3];
   logic [30:0]        q12_ff [3];
   logic [2:0]         neg12_ff;
   logic [63:0]        qsum13_ff;
   nrm_type            nrm13;

   // scale and divide
   logic        v14;
   logic [31:0] root14;
   nrm_type     nrm14;
   logic        v15_ff;
   logic [62:0] num15_ff [3];
   logic [31:0] root15_ff;
   logic [2:0]  neg15_ff;
   logic [2:0]  lane_valid;
   logic [31:0] quo [3];
   lane_type    lane_out [3];
   logic [31:0] sat_in [3];

   logic        rsp_valid_ff;
   coord_type   steer_ff [3];

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_limit_ff  <= CfgResetValue;
         accel_limit_ff <= CfgResetValue;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrPredictTimeLimit: time_limit_ff  <= csr_write_data;
            CsrAccelLimit:       accel_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign tp[0]  = req_tgt_pos_x;
   assign tp[1]  = req_tgt_pos_y;
   assign tp[2]  = req_tgt_pos_z;
   assign tvi[0] = req_tgt_vel_x;
   assign tvi[1] = req_tgt_vel_y;
   assign tvi[2] = req_tgt_vel_z;
   assign op[0]  = req_own_pos_x;
   assign op[1]  = req_own_pos_y;
   assign op[2]  = req_own_pos_z;
   assign ov[0]  = req_own_vel_x;
   assign ov[1]  = req_own_vel_y;
   assign ov[2]  = req_own_vel_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i]  = {tp[i][31], tp[i]} - {op[i][31], op[i]};
         dm_in[i] = d_in[i][32] ? 33'(-d_in[i]) : 33'(d_in[i]);
         vm_in[i] = ov[i][31] ? 32'(-ov[i]) : 32'(ov[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v15_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= req_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v6_ff  <= v5;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v15_ff <= v14;
         rsp_valid_ff <= &lane_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i]   <= d_in[i];
            dm1_ff[i]  <= dm_in[i];
            vm1_ff[i]  <= vm_in[i];
            tv1_ff[i]  <= tvi[i];
            dsq2_ff[i] <= 66'(dm1_ff[i]) * 66'(dm1_ff[i]);
            vsq2_ff[i] <= 64'(vm1_ff[i]) * 64'(vm1_ff[i]);
            d2_ff[i]   <= d1_ff[i];
            tv2_ff[i]  <= tv1_ff[i];
         end
         dsum3_ff <= dsq2_ff[0] + dsq2_ff[1] + dsq2_ff[2];
         vsum3_ff <= vsq2_ff[0] + vsq2_ff[1] + vsq2_ff[2];
         for (int i = 0; i < 3; i++) begin
            kin3.tv[i] <= tv2_ff[i];
            kin3.d[i]  <= d2_ff[i];
         end
      end
   end

   psv_isqrt #(.IN_WIDTH(66), .SIDE_WIDTH($bits(kin_type))) u_dist_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v3_ff),
      .radicand  (dsum3_ff),
      .side_in   (kin3),
      .valid_out (v4),
      .root      (dist4),
      .side_out  (kin4)
   );

   psv_isqrt #(.IN_WIDTH(66), .SIDE_WIDTH(1)) u_speed_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v3_ff),
      .radicand  ({2'b00, vsum3_ff}),
      .side_in   (vsum3_ff == 64'd0),
      .valid_out (),
      .root      (spd4),
      .side_out  (spd_zero4)
   );

   // quotient at or above 2^32 always exceeds the limit
   assign tside_in.tsat = spd_zero4 || ({16'd0, dist4[32:16]} >= spd4);
   assign tside_in.kin  = kin4;

   psv_div #(.QUO_WIDTH(32), .DEN_WIDTH(33), .SIDE_WIDTH($bits(tside_type))) u_time_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v4),
      .rem_in    ({16'd0, dist4[32:16]}),
      .low_in    ({dist4[15:0], 16'd0}),
      .den_in    (spd4),
      .side_in   (tside_in),
      .valid_out (v5),
      .quotient  (tq5),
      .side_out  (tside5)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tvm_in[i]  = kin6_ff.tv[i][31] ? 32'(-kin6_ff.tv[i]) : kin6_ff.tv[i];
         term_in[i] = {2'b00, prod7_ff[i][62:16]};
         pd_in[i]   = {{16{d7_ff[i][32]}}, d7_ff[i]};
         pneg_in[i] = -p8_ff[i];
         shifted_in[i] = pm10_ff[i] >> sh10_ff;
      end
      pm_or = pm9_ff[0] | pm9_ff[1] | pm9_ff[2];
      sh_in = '0;
      for (int j = 31; j < 48; j++) begin
         if (pm_or[j]) begin
            sh_in = 5'(j - 30);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (tside5.tsat || tq5 >= time_limit_ff) begin
            t6_ff <= time_limit_ff;
         end else begin
            t6_ff <= tq5;
         end
         kin6_ff <= tside5.kin;
         for (int i = 0; i < 3; i++) begin
            prod7_ff[i]  <= 63'(tvm_in[i]) * 63'(t6_ff);
            tvneg7_ff[i] <= kin6_ff.tv[i][31];
            d7_ff[i]     <= kin6_ff.d[i];
            p8_ff[i]     <= tvneg7_ff[i] ? pd_in[i] - term_in[i] : pd_in[i] + term_in[i];
            pm9_ff[i]    <= p8_ff[i][48] ? pneg_in[i][47:0] : p8_ff[i][47:0];
            neg9_ff[i]   <= p8_ff[i][48];
            pm10_ff[i]   <= pm9_ff[i];
            neg10_ff[i]  <= neg9_ff[i];
            q11_ff[i]    <= shifted_in[i][30:0];
            neg11_ff[i]  <= neg10_ff[i];
            qsq12_ff[i]  <= 62'(q11_ff[i]) * 62'(q11_ff[i]);
            q12_ff[i]    <= q11_ff[i];
            neg12_ff[i]  <= neg11_ff[i];
            nrm13.q[i]   <= q12_ff[i];
            nrm13.neg[i] <= neg12_ff[i];
         end
         sh10_ff   <= sh_in;
         qsum13_ff <= 64'(qsq12_ff[0]) + 64'(qsq12_ff[1]) + 64'(qsq12_ff[2]);
      end
   end

   psv_isqrt #(.IN_WIDTH(64), .SIDE_WIDTH($bits(nrm_type))) u_norm_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (v13_ff),
      .radicand  (qsum13_ff),
      .side_in   (nrm13),
      .valid_out (v14),
      .root      (root14),
      .side_out  (nrm14)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num15_ff[i] <= 63'(nrm14.q[i]) * 63'(accel_limit_ff);
         end
         root15_ff <= root14;
         neg15_ff  <= nrm14.neg;
      end
   end

   // each component is at most the root, so the quotient stays below 2^32
   for (genvar i = 0; i < 3; i++) begin : g_lane
      lane_type lane_in;

      assign lane_in.zero = (root15_ff == 32'd0);
      assign lane_in.neg  = neg15_ff[i];

      psv_div #(.QUO_WIDTH(32), .DEN_WIDTH(32), .SIDE_WIDTH($bits(lane_type))) u_scale_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (v15_ff),
         .rem_in    ({1'b0, num15_ff[i][62:32]}),
         .low_in    (num15_ff[i][31:0]),
         .den_in    (root15_ff),
         .side_in   (lane_in),
         .valid_out (lane_valid[i]),
         .quotient  (quo[i]),
         .side_out  (lane_out[i])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (lane_out[i].zero) begin
            sat_in[i] = '0;
         end else if (lane_out[i].neg) begin
            sat_in[i] = (quo[i] > NegMaxMag) ? NegMaxMag : 32'(-quo[i]);
         end else begin
            sat_in[i] = (quo[i] > PosMax) ? PosMax : quo[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            steer_ff[i] <= coord_type'(sat_in[i]);
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_steer_x = steer_ff[0];
   assign rsp_steer_y = steer_ff[1];
   assign rsp_steer_z = steer_ff[2];

endmodule

// ===== rtl/core/psv_checker.sv =====
module psv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input psv_pkg::coord_type rsp_steer_x,
   input psv_pkg::coord_type rsp_steer_y,
   input psv_pkg::coord_type rsp_steer_z
);

   // stalled result beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped under stall");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_steer_x) && $stable(rsp_steer_y) && $stable(rsp_steer_z))
      else $error("result payload changed under stall");

   // input side is held exactly while the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind pursue_steering_vector_core psv_checker u_psv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_steer_x (rsp_steer_x),
   .rsp_steer_y (rsp_steer_y),
   .rsp_steer_z (rsp_steer_z)
);
